// ----- rtl/core/cbme_pkg.sv -----
package cbme_pkg;

  // Register map, one 32-bit register every four bytes
  typedef enum logic [2:0] {
    REG_POINT_START         = 3'd0,
    REG_POINT_FIRST_HANDLE  = 3'd1,
    REG_POINT_SECOND_HANDLE = 3'd2,
    REG_POINT_END           = 3'd3,
    REG_TIME_SCALE          = 3'd4
  } reg_idx_t;

  localparam logic [31:0] TIME_SCALE_RESET = 32'h0001_0000;
  localparam logic [16:0] PHASE_ONE        = 17'h1_0000;

  // Wide enough for the second-difference operands of the acceleration term
  typedef logic signed [34:0] lval_t;

  // p + floor(((q - p) * u + 0.5) / 1.0), with u in Q1.16
  function automatic lval_t lerp(input lval_t p, input lval_t q, input logic [16:0] u);
    logic signed [35:0] diff;
    logic signed [53:0] y;
    diff = 36'(q) - 36'(p);
    y    = 54'(diff) * 54'($signed({1'b0, u})) + 54'sd32768;
    return lval_t'(36'(p) + 36'(y >>> 16));
  endfunction

  // Clamp a sign and magnitude pair to a signed 32-bit word
  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [31:0] res;
    if (!neg) begin
      res = (mag > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      res = (mag >= 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/cubic_bezier_motion_eval.sv -----
// A phase passes each stage register and the output register before its out_valid beat.
// Throughput: one phase per clock; busy is never raised and out_valid may
// fire on every cycle, one beat per accepted phase, in order.
// Depth follows acceleration: two time-scale products, each split and summed a stage later.
// Reset (rst_n low, synchronous) clears the pipeline valids, the control
// points to zero and time_scale to 1.0; no result is in flight afterward.
module cubic_bezier_motion_eval (
  input  logic               clk,
  input  logic               rst_n,
  // phase channel
  input  logic               start,
  output logic               busy,
  input  logic [16:0]        in_phase,
  // result channel
  output logic               out_valid,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_velocity,
  output logic signed [31:0] out_acceleration,
  output logic               out_range_error,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [31:0] point_start_r;
  logic signed [31:0] point_first_handle_r;
  logic signed [31:0] point_second_handle_r;
  logic signed [31:0] point_end_r;
  logic [31:0]        time_scale_r;
  logic               cfg_wr;
  cbme_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = cbme_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_start_r         <= '0;
      point_first_handle_r  <= '0;
      point_second_handle_r <= '0;
      point_end_r           <= '0;
      time_scale_r          <= cbme_pkg::TIME_SCALE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cbme_pkg::REG_POINT_START:         point_start_r         <= pwdata;
        cbme_pkg::REG_POINT_FIRST_HANDLE:  point_first_handle_r  <= pwdata;
        cbme_pkg::REG_POINT_SECOND_HANDLE: point_second_handle_r <= pwdata;
        cbme_pkg::REG_POINT_END:           point_end_r           <= pwdata;
        cbme_pkg::REG_TIME_SCALE:          time_scale_r          <= pwdata;
        default: ; // drop writes beyond the map
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cbme_pkg::REG_POINT_START:         prdata = point_start_r;
      cbme_pkg::REG_POINT_FIRST_HANDLE:  prdata = point_first_handle_r;
      cbme_pkg::REG_POINT_SECOND_HANDLE: prdata = point_second_handle_r;
      cbme_pkg::REG_POINT_END:           prdata = point_end_r;
      cbme_pkg::REG_TIME_SCALE:          prdata = time_scale_r;
      default:                           prdata = '0;
    endcase
  end

  // The pipeline never stalls, so a phase is taken on every cycle.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 1: first de Casteljau level for position, first differences
  // for velocity, second differences for acceleration.
  // ---------------------------------------------------------------------
  cbme_pkg::lval_t pa, pb, pc, pd;
  cbme_pkg::lval_t d_ab, d_bc, d_cd;
  cbme_pkg::lval_t dd_0, dd_1;
  cbme_pkg::lval_t s1_ab_nxt, s1_bc_nxt, s1_cd_nxt;
  cbme_pkg::lval_t s1_e0_nxt, s1_e1_nxt, s1_acc_nxt;

  logic               s1_valid_r, s1_err_r;
  logic [16:0]        s1_u_r;
  logic signed [31:0] s1_ab_r, s1_bc_r, s1_cd_r;
  logic signed [32:0] s1_e0_r, s1_e1_r;
  logic signed [34:0] s1_acc_r;

  always_comb begin
    pa   = cbme_pkg::lval_t'(point_start_r);
    pb   = cbme_pkg::lval_t'(point_first_handle_r);
    pc   = cbme_pkg::lval_t'(point_second_handle_r);
    pd   = cbme_pkg::lval_t'(point_end_r);
    d_ab = pb - pa;
    d_bc = pc - pb;
    d_cd = pd - pc;
    // control points of the second derivative
    dd_0 = d_bc - d_ab;
    dd_1 = d_cd - d_bc;
    s1_ab_nxt  = cbme_pkg::lerp(pa, pb, in_phase);
    s1_bc_nxt  = cbme_pkg::lerp(pb, pc, in_phase);
    s1_cd_nxt  = cbme_pkg::lerp(pc, pd, in_phase);
    s1_e0_nxt  = cbme_pkg::lerp(d_ab, d_bc, in_phase);
    s1_e1_nxt  = cbme_pkg::lerp(d_bc, d_cd, in_phase);
    s1_acc_nxt = cbme_pkg::lerp(dd_0, dd_1, in_phase);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    s1_err_r <= in_phase > cbme_pkg::PHASE_ONE;
    s1_u_r   <= in_phase;
    s1_ab_r  <= s1_ab_nxt[31:0];
    s1_bc_r  <= s1_bc_nxt[31:0];
    s1_cd_r  <= s1_cd_nxt[31:0];
    s1_e0_r  <= s1_e0_nxt[32:0];
    s1_e1_r  <= s1_e1_nxt[32:0];
    s1_acc_r <= s1_acc_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 2: second position level, velocity lerp, acceleration times six
  // as sign and magnitude.
  // ---------------------------------------------------------------------
  cbme_pkg::lval_t    s2_abc_nxt, s2_bcd_nxt, s2_v_nxt;
  logic signed [37:0] acc_x, acc6;
  logic [37:0]        acc6_mag;

  logic               s2_valid_r, s2_err_r;
  logic [16:0]        s2_u_r;
  logic signed [31:0] s2_abc_r, s2_bcd_r;
  logic signed [32:0] s2_v_r;
  logic [35:0]        s2_am_r;
  logic               s2_an_r;

  always_comb begin
    s2_abc_nxt = cbme_pkg::lerp(cbme_pkg::lval_t'(s1_ab_r), cbme_pkg::lval_t'(s1_bc_r), s1_u_r);
    s2_bcd_nxt = cbme_pkg::lerp(cbme_pkg::lval_t'(s1_bc_r), cbme_pkg::lval_t'(s1_cd_r), s1_u_r);
    s2_v_nxt   = cbme_pkg::lerp(cbme_pkg::lval_t'(s1_e0_r), cbme_pkg::lval_t'(s1_e1_r), s1_u_r);
    acc_x      = 38'(s1_acc_r);
    acc6       = (acc_x <<< 2) + (acc_x <<< 1);
    acc6_mag   = acc6[37] ? (38'd0 - acc6) : acc6;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_err_r <= s1_err_r;
    s2_u_r   <= s1_u_r;
    s2_abc_r <= s2_abc_nxt[31:0];
    s2_bcd_r <= s2_bcd_nxt[31:0];
    s2_v_r   <= s2_v_nxt[32:0];
    s2_am_r  <= acc6_mag[35:0];
    s2_an_r  <= acc6[37];
  end

  // ---------------------------------------------------------------------
  // Stage 3: final position lerp, velocity times three, first time-scale
  // partial products for acceleration.
  // ---------------------------------------------------------------------
  cbme_pkg::lval_t    s3_pos_nxt;
  logic signed [35:0] vel_x, vel3;
  logic [35:0]        vel3_mag;

  logic               s3_valid_r, s3_err_r;
  logic signed [31:0] s3_pos_r;
  logic [33:0]        s3_vm_r;
  logic               s3_vn_r;
  logic [55:0]        s3_app_lo_r;
  logic [43:0]        s3_app_hi_r;
  logic               s3_an_r;

  always_comb begin
    s3_pos_nxt = cbme_pkg::lerp(cbme_pkg::lval_t'(s2_abc_r), cbme_pkg::lval_t'(s2_bcd_r), s2_u_r);
    vel_x      = 36'(s2_v_r);
    vel3       = (vel_x <<< 1) + vel_x;
    vel3_mag   = vel3[35] ? (36'd0 - vel3) : vel3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_err_r    <= s2_err_r;
    s3_pos_r    <= s3_pos_nxt[31:0];
    s3_vm_r     <= vel3_mag[33:0];
    s3_vn_r     <= vel3[35];
    s3_app_lo_r <= 56'(s2_am_r[23:0]) * 56'(time_scale_r);
    s3_app_hi_r <= 44'(s2_am_r[35:24]) * 44'(time_scale_r);
    s3_an_r     <= s2_an_r;
  end

  // ---------------------------------------------------------------------
  // Stage 4: velocity partial products; sum and round the first
  // acceleration product. Beyond 2^47 the second scaling saturates for any
  // nonzero time scale, so clamp there to keep the next product narrow.
  // ---------------------------------------------------------------------
  logic [67:0] a1_prod;
  logic [51:0] a1_mag;
  logic [47:0] a1_clamp;

  logic               s4_valid_r, s4_err_r;
  logic signed [31:0] s4_pos_r;
  logic [55:0]        s4_vpp_lo_r;
  logic [41:0]        s4_vpp_hi_r;
  logic               s4_vn_r;
  logic [47:0]        s4_am1_r;
  logic               s4_an_r;

  always_comb begin
    a1_prod  = {s3_app_hi_r, 24'd0} + 68'(s3_app_lo_r) + 68'd32768;
    a1_mag   = a1_prod[67:16];
    a1_clamp = (a1_mag[51:47] != 5'd0) ? 48'h8000_0000_0000 : a1_mag[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_err_r    <= s3_err_r;
    s4_pos_r    <= s3_pos_r;
    s4_vpp_lo_r <= 56'(s3_vm_r[23:0]) * 56'(time_scale_r);
    s4_vpp_hi_r <= 42'(s3_vm_r[33:24]) * 42'(time_scale_r);
    s4_vn_r     <= s3_vn_r;
    s4_am1_r    <= a1_clamp;
    s4_an_r     <= s3_an_r;
  end

  // ---------------------------------------------------------------------
  // Stage 5: finish velocity (round half away from zero, saturate);
  // second time-scale partial products for acceleration.
  // ---------------------------------------------------------------------
  logic [65:0] v_prod;

  logic               s5_valid_r, s5_err_r;
  logic signed [31:0] s5_pos_r;
  logic signed [31:0] s5_vel_r;
  logic [55:0]        s5_app_lo_r;
  logic [55:0]        s5_app_hi_r;
  logic               s5_an_r;

  assign v_prod = {s4_vpp_hi_r, 24'd0} + 66'(s4_vpp_lo_r) + 66'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
    s5_err_r    <= s4_err_r;
    s5_pos_r    <= s4_pos_r;
    s5_vel_r    <= cbme_pkg::sat_mag(s4_vn_r, 64'(v_prod[65:16]));
    s5_app_lo_r <= 56'(s4_am1_r[23:0]) * 56'(time_scale_r);
    s5_app_hi_r <= 56'(s4_am1_r[47:24]) * 56'(time_scale_r);
    s5_an_r     <= s4_an_r;
  end

  // ---------------------------------------------------------------------
  // Output register: finish acceleration, zero the beat on a range error.
  // ---------------------------------------------------------------------
  logic [79:0] a2_prod;
  logic [31:0] acc_sat;

  logic               out_valid_r, out_err_r;
  logic signed [31:0] out_pos_r, out_vel_r, out_acc_r;

  always_comb begin
    a2_prod = {s5_app_hi_r, 24'd0} + 80'(s5_app_lo_r) + 80'd32768;
    acc_sat = cbme_pkg::sat_mag(s5_an_r, a2_prod[79:16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s5_valid_r;
    end
    out_err_r <= s5_err_r;
    out_pos_r <= s5_err_r ? 32'sd0 : s5_pos_r;
    out_vel_r <= s5_err_r ? 32'sd0 : s5_vel_r;
    out_acc_r <= s5_err_r ? 32'sd0 : acc_sat;
  end

  assign out_valid        = out_valid_r;
  assign out_range_error  = out_err_r;
  assign out_position     = out_pos_r;
  assign out_velocity     = out_vel_r;
  assign out_acceleration = out_acc_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_beat_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result beat without an accepted phase six cycles earlier");

  a_err_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_range_error == ($past(in_phase, 6) > cbme_pkg::PHASE_ONE)))
    else $error("range error flag does not match the accepted phase");

  a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |->
      out_position == 32'sd0 && out_velocity == 32'sd0 && out_acceleration == 32'sd0)
    else $error("range error beat carries nonzero values");

  a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && time_scale_r == 32'd0 |->
      out_velocity == 32'sd0 && out_acceleration == 32'sd0)
    else $error("zero time scale gave a nonzero derivative");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int PIPE_DEPTH  = 6;     // start beat to out_valid beat
  localparam int QUIET_LIMIT = 4000;  // cycles with no beat of any kind
  localparam int SETTINGS_N  = 11;    // random register settings
  localparam int PER_SETTING = 105;   // phases issued under each setting
  localparam logic [63:0] MAG_CAP = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
    logic        range_error;
  } motion_t;

  // Hold every input at a known value from time zero
  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        start    = 1'b0;
  logic [16:0] in_phase = '0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;

  logic               busy;
  logic               out_valid;
  logic signed [31:0] out_position;
  logic signed [31:0] out_velocity;
  logic signed [31:0] out_acceleration;
  logic               out_range_error;
  logic [31:0]        prdata;
  logic               pready;

  // Phases waiting to be driven, and the motion samples the block owes us
  logic [16:0] phase_q [$];
  motion_t     motion_q [$];

  // Our own copy of the register file, updated on each completed write
  logic [31:0] shadow_regs [0:4];

  int gap_left   = 0;
  int idle_pct   = 0;
  int mismatches = 0;
  int quiet      = 0;

  cubic_bezier_motion_eval DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_phase         (in_phase),
    .out_valid        (out_valid),
    .out_position     (out_position),
    .out_velocity     (out_velocity),
    .out_acceleration (out_acceleration),
    .out_range_error  (out_range_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Motion predictor
  // ---------------------------------------------------------------------

  // Move from p toward q by u (Q1.16), rounding half up; >>> floors.
  function automatic longint blend(input longint p, input longint q, input longint u);
    longint y;
    y = (q - p) * u + 64'sd32768;
    return p + (y >>> 16);
  endfunction

  // x * ts / 65536 with halves rounded away from zero. The magnitude is
  // held at 2^62 on the way in and out, which the final clamp hides.
  function automatic longint time_scaled(input longint x, input logic [31:0] ts);
    logic [63:0] mag;
    logic [95:0] prod;
    logic [63:0] r;
    mag  = (x < 0) ? 64'(-x) : 64'(x);
    if (mag > MAG_CAP) mag = MAG_CAP;
    prod = (({32'd0, mag} * {64'd0, ts}) + 96'd32768) >> 16;
    r    = (prod > {32'd0, MAG_CAP}) ? MAG_CAP : prod[63:0];
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // Position by de Casteljau, velocity from the first differences and
  // acceleration from the second differences, both taken to real time.
  function automatic motion_t eval_motion(input logic [16:0] ph);
    motion_t m;
    longint  u, a, b, c, d, ab, bc, cd, e0, e1, vel, acc;
    m = '0;
    if (ph > cbme_pkg::PHASE_ONE) begin
      m.range_error = 1'b1;
      return m;
    end
    u  = longint'(ph);
    a  = longint'($signed(shadow_regs[cbme_pkg::REG_POINT_START]));
    b  = longint'($signed(shadow_regs[cbme_pkg::REG_POINT_FIRST_HANDLE]));
    c  = longint'($signed(shadow_regs[cbme_pkg::REG_POINT_SECOND_HANDLE]));
    d  = longint'($signed(shadow_regs[cbme_pkg::REG_POINT_END]));
    ab = blend(a, b, u);
    bc = blend(b, c, u);
    cd = blend(c, d, u);
    m.position = clamp32(blend(blend(ab, bc, u), blend(bc, cd, u), u));
    e0  = blend(b - a, c - b, u);
    e1  = blend(c - b, d - c, u);
    vel = time_scaled(3 * blend(e0, e1, u), shadow_regs[cbme_pkg::REG_TIME_SCALE]);
    m.velocity = clamp32(vel);
    acc = 6 * blend(c - 2 * b + a, d - 2 * c + b, u);
    acc = time_scaled(time_scaled(acc, shadow_regs[cbme_pkg::REG_TIME_SCALE]),
                      shadow_regs[cbme_pkg::REG_TIME_SCALE]);
    m.acceleration = clamp32(acc);
    return m;
  endfunction

  // ---------------------------------------------------------------------
  // Phase driver: pop the next phase, hold it while busy, and insert
  // random idle bursts after a beat when the current setting asks for it.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      // Predict at the accepting edge, with the registers in force now
      if (start && !busy) motion_q.push_back(eval_motion(in_phase));
      if (start && busy) begin
        // hold the beat until the block takes it
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (phase_q.size() != 0) begin
        start    <= 1'b1;
        in_phase <= phase_q.pop_front();
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          gap_left <= $urandom_range(1, 18);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: every out_valid beat must match the oldest prediction
  // ---------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    motion_t want;
    if (rst_n && out_valid) begin
      if (motion_q.size() == 0) begin
        flag_mismatch("unexpected beat, position", out_position, 32'h0);
      end else begin
        want = motion_q.pop_front();
        if (out_position !== want.position)
          flag_mismatch("position", out_position, want.position);
        if (out_velocity !== want.velocity)
          flag_mismatch("velocity", out_velocity, want.velocity);
        if (out_acceleration !== want.acceleration)
          flag_mismatch("acceleration", out_acceleration, want.acceleration);
        if (out_range_error !== want.range_error)
          flag_mismatch("range_error", 32'(out_range_error), 32'(want.range_error));
      end
    end
  end

  // Watchdog: end the run when no beat of any kind moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL cubic_bezier_motion_eval");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Write with a setup phase, then an access phase; the register takes the value at
  // the edge where psel, penable, pwrite and pready are all high.
  task automatic write_reg(input cbme_pkg::reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_regs[idx] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_curve(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic [31:0] d,
                            input logic [31:0] ts);
    write_reg(cbme_pkg::REG_POINT_START, a);
    write_reg(cbme_pkg::REG_POINT_FIRST_HANDLE, b);
    write_reg(cbme_pkg::REG_POINT_SECOND_HANDLE, c);
    write_reg(cbme_pkg::REG_POINT_END, d);
    write_reg(cbme_pkg::REG_TIME_SCALE, ts);
  endtask

  // Pause the sender until every predicted beat has come back, then let
  // the pipeline empty. Sample at the falling edge to stay clear of the
  // driver's updates at the rising one.
  task automatic drain();
    do @(negedge clk); while (phase_q.size() != 0 || start || motion_q.size() != 0);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Control point: full-range word, a modest value, or a rail
  function automatic logic [31:0] draw_point();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [31:0] draw_time_scale();
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return cbme_pkg::TIME_SCALE_RESET;
      3: return $urandom;
      4: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom_range(32'h0000_4000, 32'h0100_0000);
    endcase
  endfunction

  // Mostly in-range phases, some at the ends, some beyond one
  function automatic logic [16:0] draw_phase();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 17'($urandom_range(32'h1_0001, 32'h1_FFFF));
    if (r < 14) begin
      case ($urandom_range(0, 3))
        0: return 17'd0;
        1: return 17'd1;
        2: return cbme_pkg::PHASE_ONE - 17'd1;
        default: return cbme_pkg::PHASE_ONE;
      endcase
    end
    return 17'($urandom_range(0, 32'h1_0000));
  endfunction

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    shadow_regs[cbme_pkg::REG_POINT_START]         = '0;
    shadow_regs[cbme_pkg::REG_POINT_FIRST_HANDLE]  = '0;
    shadow_regs[cbme_pkg::REG_POINT_SECOND_HANDLE] = '0;
    shadow_regs[cbme_pkg::REG_POINT_END]           = '0;
    shadow_regs[cbme_pkg::REG_TIME_SCALE]          = cbme_pkg::TIME_SCALE_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: flat curve, plus the range flag past one, with one itself in range
    idle_pct = 0;
    phase_q = '{17'd0, 17'd32768, cbme_pkg::PHASE_ONE, cbme_pkg::PHASE_ONE + 17'd1,
                17'h1_FFFF};
    drain();

    // Alternating rails at the largest time scale: saturate velocity and acceleration
    // and push the scaled intermediates into the magnitude cap
    load_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    phase_q = '{17'd0, 17'd1, 17'd32768, cbme_pkg::PHASE_ONE - 17'd1, cbme_pkg::PHASE_ONE,
                17'h1_5555, 17'h0_AAAA};
    drain();

    // Zero time scale: derivatives vanish, position still moves
    load_curve(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    phase_q = '{17'd0, 17'd21845, cbme_pkg::PHASE_ONE, 17'h1_FFFF};
    drain();

    // Random curves; each setting ends with the sender paused until the
    // last beat is back, and the final one runs without idle bursts
    for (int s = 0; s < SETTINGS_N; s++) begin
      load_curve(draw_point(), draw_point(), draw_point(), draw_point(), draw_time_scale());
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 35;
      endcase
      if (s == SETTINGS_N - 1) idle_pct = 0;
      for (int k = 0; k < PER_SETTING; k++) phase_q.push_back(draw_phase());
      drain();
    end

    if (motion_q.size() != 0)
      flag_mismatch("beats never returned", 32'(motion_q.size()), 32'h0);
    if (mismatches == 0) begin
      $display("PASS cubic_bezier_motion_eval");
    end else begin
      $display("FAIL cubic_bezier_motion_eval");
    end
    $finish;
  end

endmodule
